FILE: src/rgd_pkg.sv
// Shared types, constants and helper functions of the roll gesture detector.
package rgd_pkg;

  // Number of samples kept in the window.
  localparam int unsigned WINDOW = 8;

  // Sum of the squares 1..n, used to size the weight accumulators.
  function automatic int unsigned weight_total(input int unsigned n);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 1; k <= n; k++) begin
      acc += k * k;
    end
    return acc;
  endfunction

  localparam int unsigned SUM_W  = $clog2(weight_total(WINDOW) + 1);
  localparam int unsigned PROD_W = SUM_W + 9;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  // Weight of the delta that ends at window position pos.
  function automatic logic [SUM_W-1:0] pos_weight(input int unsigned pos);
    return SUM_W'((pos + 1) * (pos + 1));
  endfunction

  // Gesture codes.
  localparam logic [1:0] G_NONE  = 2'd0;
  localparam logic [1:0] G_LEFT  = 2'd1;
  localparam logic [1:0] G_RIGHT = 2'd2;

  // Item opcodes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACT_THR  = 2'd0;
  localparam logic [1:0] CFG_GEST_THR = 2'd1;
  localparam logic [1:0] CFG_MIN_MS   = 2'd2;

  // Window control broadcast to every cell.
  typedef struct packed {
    logic clear;
    logic push;
    logic full;
  } cell_ctrl_t;

endpackage

FILE: src/roll_gesture_detector.sv
// Top level of the roll gesture detector: window cell chain, decision logic and ports.
//
// A roll sample is taken, stored in a chain of WINDOW cells, and answered once the weighted
// activity sums have rippled through the cell chain one cell per cycle and met the final
// threshold compare; the block takes no new item until that answer has gone into the output
// register, which a stalled output can hold back. A clear item is registered into the output
// in the cycle it is taken and leaves the block free in the next one. Configuration writes
// are always taken; there is no clearing pass after reset.
module roll_gesture_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] roll_sample_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        changed_o,
  output logic [1:0]  active_gesture_o,
  output logic [1:0]  recognized_gesture_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  // Configuration registers.
  logic [14:0] act_thr_q;
  logic [8:0]  gest_thr_q;
  logic [15:0] min_ms_q;

  // Control and gesture state.
  logic                      state_q;
  logic [rgd_pkg::CNT_W-1:0] cnt_q;
  logic [1:0]                rec_q;
  logic [31:0]               rec_start_q;
  logic [1:0]                act_q;
  logic [31:0]               act_start_q;
  logic [15:0]               newest_q;
  logic [31:0]               now_q;

  // Output register.
  logic       out_valid_q;
  logic       changed_q;
  logic [1:0] act_out_q;
  logic [1:0] rec_out_q;

  // Cell chain signals.
  rgd_pkg::cell_ctrl_t       ctrl;
  logic [15:0]               samp  [rgd_pkg::WINDOW];
  logic                      valid [rgd_pkg::WINDOW];
  logic [rgd_pkg::SUM_W-1:0] psum  [rgd_pkg::WINDOW];
  logic [rgd_pkg::SUM_W-1:0] beta  [rgd_pkg::WINDOW];

  logic in_accept;
  logic out_free;
  logic decide;

  // Decision terms.
  logic [rgd_pkg::PROD_W-1:0] lhs;
  logic [rgd_pkg::PROD_W-1:0] rhs;
  logic                       likely;
  logic                       left;
  logic                       held;
  logic [31:0]                rec_age;
  logic [31:0]                act_age;
  logic [1:0]                 rec_d;
  logic [31:0]                rec_start_d;
  logic [1:0]                 act_d;
  logic [31:0]                act_start_d;
  logic                       changed_d;

  // Handshakes: a clear answers at once and so needs the output register free.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q == S_EVAL) || ((opcode_i == rgd_pkg::OP_CLEAR) && !out_free);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_thr_q  <= 15'd41;
      gest_thr_q <= 9'd128;
      min_ms_q   <= 16'd500;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rgd_pkg::CFG_ACT_THR:  act_thr_q  <= cfg_data_i[14:0];
        rgd_pkg::CFG_GEST_THR: gest_thr_q <= cfg_data_i[8:0];
        rgd_pkg::CFG_MIN_MS:   min_ms_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Window control broadcast.
  assign ctrl.clear = in_accept && (opcode_i == rgd_pkg::OP_CLEAR);
  assign ctrl.push  = in_accept && (opcode_i == rgd_pkg::OP_SAMPLE);
  assign ctrl.full  = valid[rgd_pkg::WINDOW-1];

  // Chain of window cells, oldest sample in cell zero.
  for (genvar i = 0; i < rgd_pkg::WINDOW; i++) begin : g_cell
    logic [15:0]               prev_sample;
    logic                      prev_valid;
    logic [15:0]               next_sample;
    logic [rgd_pkg::SUM_W-1:0] psum_in;
    logic [rgd_pkg::SUM_W-1:0] beta_in;

    if (i == 0) begin : g_first
      assign prev_sample = '0;
      assign prev_valid  = 1'b1;
      assign psum_in     = '0;
      assign beta_in     = '0;
    end else begin : g_rest
      assign prev_sample = samp[i-1];
      assign prev_valid  = valid[i-1];
      assign psum_in     = psum[i-1];
      assign beta_in     = beta[i-1];
    end

    if (i == rgd_pkg::WINDOW - 1) begin : g_last
      assign next_sample = roll_sample_i;
    end else begin : g_mid
      assign next_sample = samp[i+1];
    end

    rgd_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_sample_i  (roll_sample_i),
      .prev_sample_i (prev_sample),
      .prev_valid_i  (prev_valid),
      .has_prev_i    (i != 0),
      .next_sample_i (next_sample),
      .weight_i      (rgd_pkg::pos_weight(i)),
      .act_thr_i     (act_thr_q),
      .psum_i        (psum_in),
      .beta_i        (beta_in),
      .sample_o      (samp[i]),
      .valid_o       (valid[i]),
      .psum_o        (psum[i]),
      .beta_o        (beta[i])
    );
  end

  // Sequencer: wait for the sums to reach the last cell, then decide.
  assign decide = (state_q == S_EVAL) && (cnt_q == '0) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (ctrl.push) begin
            state_q <= S_EVAL;
            cnt_q   <= rgd_pkg::CNT_W'(rgd_pkg::WINDOW);
          end
        end
        S_EVAL: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end else if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.push) begin
      newest_q <= roll_sample_i;
      now_q    <= now_ms_i;
    end
  end

  // Likelihood compare: sum * 256 against threshold * total weight.
  assign lhs    = rgd_pkg::PROD_W'({psum[rgd_pkg::WINDOW-1], 8'd0});
  assign rhs    = rgd_pkg::PROD_W'(gest_thr_q) * rgd_pkg::PROD_W'(beta[rgd_pkg::WINDOW-1]);
  assign likely = lhs >= rhs;
  assign left   = $signed(newest_q) >= $signed(samp[0]);

  // Recognized and active gesture update.
  assign rec_age = now_q - rec_start_q;
  assign held    = (rec_q != rgd_pkg::G_NONE) && (rec_age < {16'd0, min_ms_q});

  always_comb begin
    rec_d       = rec_q;
    rec_start_d = rec_start_q;
    if (!held) begin
      if ((rec_q == rgd_pkg::G_NONE) && likely) begin
        rec_d       = left ? rgd_pkg::G_LEFT : rgd_pkg::G_RIGHT;
        rec_start_d = now_q;
      end else if ((rec_q != rgd_pkg::G_NONE) && !likely) begin
        rec_d = rgd_pkg::G_NONE;
      end
    end
  end

  assign act_age = now_q - act_start_q;

  always_comb begin
    act_d       = act_q;
    act_start_d = act_start_q;
    changed_d   = 1'b0;
    if ((act_q == rgd_pkg::G_NONE) && (rec_d != rgd_pkg::G_NONE) &&
        (act_age > {16'd0, min_ms_q})) begin
      act_d       = rec_d;
      act_start_d = rec_start_d;
      changed_d   = 1'b1;
    end else if (((act_q == rgd_pkg::G_LEFT) && (rec_d == rgd_pkg::G_RIGHT)) ||
                 ((act_q == rgd_pkg::G_RIGHT) && (rec_d == rgd_pkg::G_LEFT))) begin
      act_d       = rgd_pkg::G_NONE;
      act_start_d = rec_start_d;
      changed_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q       <= rgd_pkg::G_NONE;
      rec_start_q <= '0;
      act_q       <= rgd_pkg::G_NONE;
      act_start_q <= '0;
    end else if (ctrl.clear) begin
      rec_q       <= rgd_pkg::G_NONE;
      rec_start_q <= now_ms_i;
      act_q       <= rgd_pkg::G_NONE;
      act_start_q <= now_ms_i;
    end else if (decide) begin
      rec_q       <= rec_d;
      rec_start_q <= rec_start_d;
      act_q       <= act_d;
      act_start_q <= act_start_d;
    end
  end

  // Output register: loaded on a clear or a decision, freed by a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.clear || decide) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      changed_q <= 1'b0;
      act_out_q <= rgd_pkg::G_NONE;
      rec_out_q <= rgd_pkg::G_NONE;
    end else if (decide) begin
      changed_q <= changed_d;
      act_out_q <= act_d;
      rec_out_q <= rec_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign changed_o            = changed_q;
  assign active_gesture_o     = act_out_q;
  assign recognized_gesture_o = rec_out_q;

endmodule

FILE: src/rgd_cell.sv
// One window cell: holds a sample, scores its delta and passes the weight sums on.
module rgd_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rgd_pkg::cell_ctrl_t       ctrl_i,
  input  logic [15:0]               new_sample_i,
  input  logic [15:0]               prev_sample_i,
  input  logic                      prev_valid_i,
  input  logic                      has_prev_i,
  input  logic [15:0]               next_sample_i,
  input  logic [rgd_pkg::SUM_W-1:0] weight_i,
  input  logic [14:0]               act_thr_i,
  input  logic [rgd_pkg::SUM_W-1:0] psum_i,
  input  logic [rgd_pkg::SUM_W-1:0] beta_i,
  output logic [15:0]               sample_o,
  output logic                      valid_o,
  output logic [rgd_pkg::SUM_W-1:0] psum_o,
  output logic [rgd_pkg::SUM_W-1:0] beta_o
);

  logic [15:0]               sample_q;
  logic                      valid_q;
  logic [rgd_pkg::SUM_W-1:0] psum_q;
  logic [rgd_pkg::SUM_W-1:0] beta_q;
  logic                      take_new;
  logic                      shift_in;
  logic signed [16:0]        delta;
  logic [16:0]               mag;
  logic                      active;

  // The first empty cell takes a new sample; a full window shifts toward cell zero.
  assign take_new = ctrl_i.push && !ctrl_i.full && !valid_q && prev_valid_i;
  assign shift_in = ctrl_i.push && ctrl_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (take_new) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_in) begin
      sample_q <= next_sample_i;
    end else if (take_new) begin
      sample_q <= new_sample_i;
    end
  end

  // Magnitude of the change from the older neighbor.
  assign delta  = $signed({sample_q[15], sample_q}) - $signed({prev_sample_i[15], prev_sample_i});
  assign mag    = delta[16] ? 17'(-delta) : 17'(delta);
  assign active = valid_q && has_prev_i && (mag > {2'b00, act_thr_i});

  // Running sums move one cell further along the chain every cycle.
  always_ff @(posedge clk_i) begin
    psum_q <= psum_i + (active ? weight_i : '0);
    beta_q <= beta_i + (valid_q ? weight_i : '0);
  end

  assign sample_o = sample_q;
  assign valid_o  = valid_q;
  assign psum_o   = psum_q;
  assign beta_o   = beta_q;

endmodule

FILE: src/rgd_checker.sv
// Port-level checks of the roll gesture detector and their binding to the top level.
module rgd_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic       changed_i,
  input logic [1:0] active_gesture_i,
  input logic [1:0] recognized_gesture_i
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(changed_i) &&
      $stable(active_gesture_i) && $stable(recognized_gesture_i))
    else $error("stalled result changed");

  // A change either latches the recognized gesture or cancels to none.
  a_change_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && changed_i && (active_gesture_i != rgd_pkg::G_NONE) |->
      active_gesture_i == recognized_gesture_i)
    else $error("changed active gesture differs from recognized gesture");

  // The active gesture never stays against the opposite recognized one.
  a_no_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      !(((active_gesture_i == rgd_pkg::G_LEFT) && (recognized_gesture_i == rgd_pkg::G_RIGHT)) ||
        ((active_gesture_i == rgd_pkg::G_RIGHT) && (recognized_gesture_i == rgd_pkg::G_LEFT))))
    else $error("active gesture opposes recognized gesture");

endmodule

bind roll_gesture_detector rgd_port_checks u_rgd_port_checks (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .changed_i            (changed_o),
  .active_gesture_i     (active_gesture_o),
  .recognized_gesture_i (recognized_gesture_o)
);
